/* hdl/mvt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform.
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int DIM      = 4;
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 3;
    localparam int COMP_W   = 32;
    localparam int PROD_W   = 2 * COMP_W;
    localparam int PSUM_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 2;

    // Register indexes of the matrix columns.
    localparam logic [ADDR_W-1:0] REG_COL0_ROWS01 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COL0_ROWS23 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COL1_ROWS01 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_COL1_ROWS23 = 3'd3;
    localparam logic [ADDR_W-1:0] REG_COL2_ROWS01 = 3'd4;
    localparam logic [ADDR_W-1:0] REG_COL2_ROWS23 = 3'd5;
    localparam logic [ADDR_W-1:0] REG_COL3_ROWS01 = 3'd6;
    localparam logic [ADDR_W-1:0] REG_COL3_ROWS23 = 3'd7;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PSUM_W-1:0] psum_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam comp_t COMP_MAX = 32'sh7FFF_FFFF;
    localparam comp_t COMP_MIN = 32'sh8000_0000;

endpackage

/* hdl/mvt_mul_stage.sv */
// Input register and the sixteen coefficient-by-component multipliers.
`timescale 1ns / 1ps

module mvt_mul_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  mvt_pkg::comp_t vec_in [mvt_pkg::DIM],
    input  mvt_pkg::comp_t coef   [mvt_pkg::DIM][mvt_pkg::DIM],
    output logic          out_valid,
    input  logic          out_ready,
    output mvt_pkg::prod_t prod   [mvt_pkg::DIM][mvt_pkg::DIM]
);

    logic           vec_valid_reg;
    mvt_pkg::comp_t vec_reg   [mvt_pkg::DIM];
    logic           prod_valid_reg;
    mvt_pkg::prod_t prod_reg  [mvt_pkg::DIM][mvt_pkg::DIM];
    mvt_pkg::prod_t prod_next [mvt_pkg::DIM][mvt_pkg::DIM];
    logic           prod_ready;
    logic           vec_ready;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign vec_ready  = !vec_valid_reg || prod_ready;
    assign in_ready   = vec_ready;

    always_comb begin
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                prod_next[r][c] = mvt_pkg::prod_t'(coef[r][c]) * mvt_pkg::prod_t'(vec_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (vec_ready) begin
                vec_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= vec_valid_reg;
            end
        end
        if (vec_ready && in_valid) begin
            vec_reg <= vec_in;
        end
        if (prod_ready && vec_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign prod      = prod_reg;

endmodule

/* hdl/mvt_add_tree.sv */
// Two registered adder levels that reduce four products per row to one sum.
`timescale 1ns / 1ps

module mvt_add_tree (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  mvt_pkg::prod_t prod [mvt_pkg::DIM][mvt_pkg::DIM],
    output logic          out_valid,
    input  logic          out_ready,
    output mvt_pkg::sum_t  sum  [mvt_pkg::DIM]
);

    logic           pair_valid_reg;
    mvt_pkg::psum_t pair_reg  [mvt_pkg::DIM][2];
    mvt_pkg::psum_t pair_next [mvt_pkg::DIM][2];
    logic           sum_valid_reg;
    mvt_pkg::sum_t  sum_reg   [mvt_pkg::DIM];
    mvt_pkg::sum_t  sum_next  [mvt_pkg::DIM];
    logic           sum_ready;
    logic           pair_ready;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign pair_ready = !pair_valid_reg || sum_ready;
    assign in_ready   = pair_ready;

    always_comb begin
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            for (int h = 0; h < 2; h++) begin
                pair_next[r][h] = mvt_pkg::psum_t'(prod[r][2*h])
                                + mvt_pkg::psum_t'(prod[r][2*h+1]);
            end
            sum_next[r] = mvt_pkg::sum_t'(pair_reg[r][0]) + mvt_pkg::sum_t'(pair_reg[r][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (pair_ready) begin
                pair_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
        if (pair_ready && in_valid) begin
            pair_reg <= pair_next;
        end
        if (sum_ready && pair_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

/* hdl/mvt_sat_stage.sv */
// Fraction shift, 32-bit saturation and the output register.
`timescale 1ns / 1ps

module mvt_sat_stage #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  mvt_pkg::sum_t  sum [mvt_pkg::DIM],
    output logic          out_valid,
    input  logic          out_ready,
    output mvt_pkg::comp_t res [mvt_pkg::DIM],
    output logic          clipped
);

    logic           res_valid_reg;
    mvt_pkg::comp_t res_reg  [mvt_pkg::DIM];
    mvt_pkg::comp_t res_next [mvt_pkg::DIM];
    logic           clipped_reg;
    logic           clipped_next;
    mvt_pkg::sum_t  shifted;
    logic           res_ready;

    assign res_ready = !res_valid_reg || out_ready;
    assign in_ready  = res_ready;

    // The shift floors; a row fits when bit 31 and all bits above it match its sign.
    always_comb begin
        clipped_next = 1'b0;
        shifted      = '0;
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            shifted = sum[r] >>> FRAC_BITS;
            if (!shifted[mvt_pkg::SUM_W-1] && (shifted[mvt_pkg::SUM_W-2:mvt_pkg::COMP_W-1] != '0)) begin
                res_next[r]  = mvt_pkg::COMP_MAX;
                clipped_next = 1'b1;
            end else if (shifted[mvt_pkg::SUM_W-1]
                         && (shifted[mvt_pkg::SUM_W-2:mvt_pkg::COMP_W-1] != '1)) begin
                res_next[r]  = mvt_pkg::COMP_MIN;
                clipped_next = 1'b1;
            end else begin
                res_next[r] = shifted[mvt_pkg::COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= in_valid;
        end
        if (res_ready && in_valid) begin
            res_reg     <= res_next;
            clipped_reg <= clipped_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign res       = res_reg;
    assign clipped   = clipped_reg;

    // A flagged result carries at least one saturated row.
    a_clip_has_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && clipped_reg |->
            res_reg[0] == mvt_pkg::COMP_MAX || res_reg[0] == mvt_pkg::COMP_MIN ||
            res_reg[1] == mvt_pkg::COMP_MAX || res_reg[1] == mvt_pkg::COMP_MIN ||
            res_reg[2] == mvt_pkg::COMP_MAX || res_reg[2] == mvt_pkg::COMP_MIN ||
            res_reg[3] == mvt_pkg::COMP_MAX || res_reg[3] == mvt_pkg::COMP_MIN)
        else $error("clipped set without a saturated row");

endmodule

/* hdl/mat4_vec4_transform.sv */
// Top level: 4x4 fixed-point matrix times 4-vector with saturation.
// m_tvalid rises once the input transaction has passed the input, multiply, two adds
// and saturate registers.
// Throughput: one vector per cycle; a stage stalls only when it is full and the stage
// after it cannot take its transaction. The multipliers and adder tree are pipelined.
// Reset (aresetn low, synchronous) empties the pipeline and loads the identity matrix.
`timescale 1ns / 1ps

module mat4_vec4_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [127:0]                s_tdata,   // x_in, y_in, z_in, w_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [127:0]                m_tdata,   // x_out, y_out, z_out, w_out
    output logic                        m_tuser,   // clipped
    input  logic                        cfg_wr_en,
    input  logic [mvt_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [mvt_pkg::REG_W-1:0]   cfg_wdata
);

    localparam logic [mvt_pkg::COMP_W-1:0] COEF_ONE = 32'd1 << FRAC_BITS;

    logic [mvt_pkg::REG_W-1:0] cfg_reg [mvt_pkg::NUM_REGS];
    mvt_pkg::comp_t coef    [mvt_pkg::DIM][mvt_pkg::DIM];
    mvt_pkg::comp_t vec_in  [mvt_pkg::DIM];
    mvt_pkg::prod_t prod    [mvt_pkg::DIM][mvt_pkg::DIM];
    mvt_pkg::sum_t  sum     [mvt_pkg::DIM];
    mvt_pkg::comp_t res     [mvt_pkg::DIM];
    logic           mul_valid;
    logic           add_ready;
    logic           add_valid;
    logic           sat_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[mvt_pkg::REG_COL0_ROWS01] <= {32'd0, COEF_ONE};
            cfg_reg[mvt_pkg::REG_COL0_ROWS23] <= '0;
            cfg_reg[mvt_pkg::REG_COL1_ROWS01] <= {COEF_ONE, 32'd0};
            cfg_reg[mvt_pkg::REG_COL1_ROWS23] <= '0;
            cfg_reg[mvt_pkg::REG_COL2_ROWS01] <= '0;
            cfg_reg[mvt_pkg::REG_COL2_ROWS23] <= {32'd0, COEF_ONE};
            cfg_reg[mvt_pkg::REG_COL3_ROWS01] <= '0;
            cfg_reg[mvt_pkg::REG_COL3_ROWS23] <= {COEF_ONE, 32'd0};
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Each register holds one column's pair of rows, the lower row in the low half.
    for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
        for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_col
            assign coef[r][c] = cfg_reg[2*c + r/2][mvt_pkg::COMP_W*(r%2) +: mvt_pkg::COMP_W];
        end
        assign vec_in[r] = s_tdata[mvt_pkg::COMP_W*r +: mvt_pkg::COMP_W];
        assign m_tdata[mvt_pkg::COMP_W*r +: mvt_pkg::COMP_W] = res[r];
    end

    mvt_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vec_in    (vec_in),
        .coef      (coef),
        .out_valid (mul_valid),
        .out_ready (add_ready),
        .prod      (prod)
    );

    mvt_add_tree u_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (add_ready),
        .prod      (prod),
        .out_valid (add_valid),
        .out_ready (sat_ready),
        .sum       (sum)
    );

    mvt_sat_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (add_valid),
        .in_ready  (sat_ready),
        .sum       (sum),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res),
        .clipped   (m_tuser)
    );

    // The pipeline can only back up to the input when the output holds a result.
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A result taken with nothing in flight behind it leaves the output empty.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !add_valid |=> !m_tvalid)
        else $error("result repeated after its transaction");

endmodule

/* tb/sv/mat4_vec4_transform_test.sv */
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform.
`timescale 1ns / 1ps

module mat4_vec4_transform_test;

    localparam int FRAC_BITS = 16;
    localparam mvt_pkg::comp_t ONE_Q = mvt_pkg::comp_t'(1) <<< FRAC_BITS;
    localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] WIDE_MIN = -128'sh8000_0000;

    typedef logic [mvt_pkg::DIM-1:0][mvt_pkg::COMP_W-1:0] vec_t;
    typedef struct packed {
        logic clipped;
        vec_t rows;
    } result_t;
    typedef logic [mvt_pkg::REG_W-1:0] reg_file_t [mvt_pkg::NUM_REGS];

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [127:0]               s_tdata   = '0;   // x_in, y_in, z_in, w_in
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [127:0]               m_tdata;          // x_out, y_out, z_out, w_out
    logic                       m_tuser;          // clipped
    logic                       cfg_wr_en = 1'b0;
    logic [mvt_pkg::ADDR_W-1:0] cfg_addr  = '0;
    logic [mvt_pkg::REG_W-1:0]  cfg_wdata = '0;

    reg_file_t matrix_regs;
    result_t   expected_rows[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        error_count    = 0;
    int        vectors_sent   = 0;
    int        results_seen   = 0;
    int        clipped_seen   = 0;
    int        matrices_used  = 1;
    string     row_name[mvt_pkg::DIM] = '{"x_out", "y_out", "z_out", "w_out"};

    mat4_vec4_transform #(.FRAC_BITS(FRAC_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Matrix builders and the transform predictor.
    function automatic reg_file_t identity_matrix();
        reg_file_t m;
        foreach (m[i]) m[i] = '0;
        m[mvt_pkg::REG_COL0_ROWS01] = {32'h0, ONE_Q};
        m[mvt_pkg::REG_COL1_ROWS01] = {ONE_Q, 32'h0};
        m[mvt_pkg::REG_COL2_ROWS23] = {32'h0, ONE_Q};
        m[mvt_pkg::REG_COL3_ROWS23] = {ONE_Q, 32'h0};
        return m;
    endfunction

    function automatic reg_file_t uniform_matrix(mvt_pkg::comp_t c);
        reg_file_t m;
        foreach (m[i]) m[i] = {c, c};
        return m;
    endfunction

    // Coefficients come in three flavors: any 32-bit value, small (within +-4.0),
    // or mostly zero with occasional small values.
    function automatic mvt_pkg::comp_t random_coef(int style);
        mvt_pkg::comp_t small_val;
        small_val = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        case (style)
            0: return $urandom;
            1: return small_val;
            default: return ($urandom_range(3) == 0) ? small_val : mvt_pkg::comp_t'(0);
        endcase
    endfunction

    function automatic reg_file_t random_matrix();
        reg_file_t m;
        int style;
        style = $urandom_range(3);
        foreach (m[i])
            m[i] = (style == 3) ? {random_coef($urandom_range(2)), random_coef($urandom_range(2))}
                                : {random_coef(style), random_coef(style)};
        return m;
    endfunction

    function automatic vec_t make_vec(mvt_pkg::comp_t x, mvt_pkg::comp_t y,
                                      mvt_pkg::comp_t z, mvt_pkg::comp_t w);
        return {w, z, y, x};
    endfunction

    function automatic vec_t random_vector();
        vec_t v;
        int pick;
        for (int i = 0; i < mvt_pkg::DIM; i++) begin
            pick = $urandom_range(9);
            if (pick < 6)
                v[i] = $urandom;
            else if (pick < 9)
                v[i] = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            else
                case ($urandom_range(4))
                    0: v[i] = mvt_pkg::COMP_MAX;
                    1: v[i] = mvt_pkg::COMP_MIN;
                    2: v[i] = '0;
                    3: v[i] = '1;
                    default: v[i] = 32'h1;
                endcase
        end
        return v;
    endfunction

    function automatic mvt_pkg::comp_t coef_at(int row, int col);
        logic [mvt_pkg::REG_W-1:0] word;
        word = matrix_regs[col * 2 + row / 2];
        return (row % 2) ? word[63:32] : word[31:0];
    endfunction

    // Exact sum of four products, arithmetic shift (floor), then 32-bit saturation.
    function automatic result_t transform_vector(vec_t v);
        result_t res;
        mvt_pkg::comp_t a, b;
        logic signed [mvt_pkg::PROD_W-1:0] prod;
        logic signed [127:0] acc;
        res.clipped = 1'b0;
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            acc = '0;
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                a = coef_at(r, c);
                b = v[c];
                prod = a * b;
                acc = acc + prod;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > WIDE_MAX) begin
                res.rows[r] = mvt_pkg::COMP_MAX;
                res.clipped = 1'b1;
            end else if (acc < WIDE_MIN) begin
                res.rows[r] = mvt_pkg::COMP_MIN;
                res.clipped = 1'b1;
            end else begin
                res.rows[r] = acc[mvt_pkg::COMP_W-1:0];
            end
        end
        return res;
    endfunction

    // Shared drivers. Each task is entered just after a rising edge.
    task automatic send_vector(vec_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_rows.push_back(transform_vector(v));
        vectors_sent++;
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_rows.size() != 0) @(posedge aclk);
    endtask

    // Only called with the pipeline empty.
    task automatic write_matrix(reg_file_t m);
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= mvt_pkg::ADDR_W'(i);
            cfg_wdata <= m[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        matrix_regs = m;
        matrices_used++;
    endtask

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: every output transaction is compared with the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rows.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %h clipped %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_rows.pop_front();
                results_seen++;
                if (m_tuser) clipped_seen++;
                for (int r = 0; r < mvt_pkg::DIM; r++)
                    if (m_tdata[r*mvt_pkg::COMP_W +: mvt_pkg::COMP_W] !== want.rows[r]) begin
                        error_count++;
                        $display("%0t: %s mismatch, expected %h, got %h", $time,
                                 row_name[r], want.rows[r],
                                 m_tdata[r*mvt_pkg::COMP_W +: mvt_pkg::COMP_W]);
                    end
                if (m_tuser !== want.clipped) begin
                    error_count++;
                    $display("%0t: clipped mismatch, expected %b, got %b",
                             $time, want.clipped, m_tuser);
                end
            end
        end
    end

    // Tests.
    task automatic test_reset_identity();
        send_vector(make_vec(32'h0, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX,
                             mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX));
        send_vector(make_vec(mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN,
                             mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN));
        send_vector(make_vec(32'hFFFF_FFFF, 32'h1, mvt_pkg::COMP_MIN, mvt_pkg::COMP_MAX));
        send_vector(make_vec(32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA, 32'hAAAA_5555));
        finish_burst();
    endtask

    task automatic test_overflow_extremes();
        write_matrix(uniform_matrix(mvt_pkg::COMP_MIN));
        send_vector(make_vec(mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN,
                             mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN));
        send_vector(make_vec(mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX,
                             mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX));
        finish_burst();
        write_matrix(uniform_matrix(mvt_pkg::COMP_MAX));
        send_vector(make_vec(mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX,
                             mvt_pkg::COMP_MAX, mvt_pkg::COMP_MAX));
        send_vector(make_vec(mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN,
                             mvt_pkg::COMP_MIN, mvt_pkg::COMP_MIN));
        send_vector(make_vec(32'h0, 32'h0, 32'h0, 32'h0));
        finish_burst();
    endtask

    // With every coefficient at 2.0 the saturation edges sit at +-2^30.
    task automatic test_saturation_edges();
        write_matrix(uniform_matrix(ONE_Q <<< 1));
        send_vector(make_vec(32'h3FFF_FFFF, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'h4000_0000, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'hC000_0000, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'hBFFF_FFFF, 32'h0, 32'h0, 32'h0));
        finish_burst();
    endtask

    // Negative sums must floor rather than round toward zero.
    task automatic test_negative_floor();
        write_matrix(uniform_matrix(32'h1));
        send_vector(make_vec(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'h1, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'hFFFF_0000, 32'h0, 32'h0, 32'h0));
        send_vector(make_vec(32'hFFFE_FFFF, 32'h0, 32'h0, 32'h0));
        finish_burst();
        write_matrix(uniform_matrix(32'hFFFF_FFFF));
        send_vector(make_vec(32'h1, 32'h0, 32'h0, 32'h0));
        finish_burst();
    endtask

    task automatic test_random_stream(int send_pct, int recv_pct, int n_sets, int per_set);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int m = 0; m < n_sets; m++) begin
            write_matrix((m == 0) ? identity_matrix() : random_matrix());
            for (int i = 0; i < per_set; i++)
                send_vector(random_vector());
            finish_burst();
        end
    endtask

    initial begin
        matrix_regs = identity_matrix();
        matrices_used = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_identity();
        test_overflow_extremes();
        test_saturation_edges();
        test_negative_floor();
        test_random_stream(0, 0, 5, 65);
        test_random_stream(62, 0, 5, 65);
        test_random_stream(0, 62, 5, 65);
        test_random_stream(33, 33, 5, 65);

        repeat (20) @(posedge aclk);
        if (expected_rows.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_rows.size());
        end
        $display("Sent %0d vectors through %0d matrix settings; %0d results checked, %0d saturated.",
                 vectors_sent, matrices_used, results_seen, clipped_seen);
        $display("Flow control covered free-running, sender gaps, receiver stalls and both.");
        if (error_count == 0) begin
            $display("mat4_vec4_transform_test: done, clean");
        end else begin
            $display("mat4_vec4_transform_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("mat4_vec4_transform_test: done, errors");
        $finish;
    end

endmodule

/* files.f */
hdl/mvt_pkg.sv
hdl/mvt_mul_stage.sv
hdl/mvt_add_tree.sv
hdl/mvt_sat_stage.sv
hdl/mat4_vec4_transform.sv
tb/sv/mat4_vec4_transform_test.sv
